FILE: src/hktt_pkg.sv
// ----------------------------------------------------------------------------
// hktt_pkg
// Shared types, codes and tables for the HID key to terminal input translator.
// ----------------------------------------------------------------------------
package hktt_pkg;

  localparam logic [15:0] PAGE_KEYBOARD = 16'h0007;

  // Modifier usages (left / right)
  localparam logic [15:0] USAGE_LCTRL  = 16'h00e0;
  localparam logic [15:0] USAGE_LSHIFT = 16'h00e1;
  localparam logic [15:0] USAGE_LALT   = 16'h00e2;
  localparam logic [15:0] USAGE_LGUI   = 16'h00e3;
  localparam logic [15:0] USAGE_RCTRL  = 16'h00e4;
  localparam logic [15:0] USAGE_RSHIFT = 16'h00e5;
  localparam logic [15:0] USAGE_RALT   = 16'h00e6;
  localparam logic [15:0] USAGE_RGUI   = 16'h00e7;

  localparam logic [15:0] USAGE_V      = 16'h0019;
  localparam logic [15:0] USAGE_INSERT = 16'h0049;
  localparam logic [15:0] USAGE_A      = 16'h0004;
  localparam logic [15:0] USAGE_Z      = 16'h001d;
  localparam logic [15:0] USAGE_1      = 16'h001e;
  localparam logic [15:0] USAGE_SLASH  = 16'h0038;
  localparam logic [15:0] USAGE_F1     = 16'h003a;
  localparam logic [15:0] USAGE_F12    = 16'h0045;

  typedef enum logic [2:0] {
    KIND_NONE  = 3'd0,
    KIND_NAMED = 3'd1,
    KIND_FUNC  = 3'd2,
    KIND_CHAR  = 3'd3,
    KIND_PASTE = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    KEY_ENTER  = 4'd0,
    KEY_ESCAPE = 4'd1,
    KEY_BKSP   = 4'd2,
    KEY_TAB    = 4'd3,
    KEY_UP     = 4'd4,
    KEY_DOWN   = 4'd5,
    KEY_LEFT   = 4'd6,
    KEY_RIGHT  = 4'd7,
    KEY_HOME   = 4'd8,
    KEY_END    = 4'd9,
    KEY_INSERT = 4'd10,
    KEY_DELETE = 4'd11,
    KEY_PGUP   = 4'd12,
    KEY_PGDN   = 4'd13
  } named_key_t;

  typedef struct packed {
    logic [15:0] hid_page;
    logic [15:0] usage_code;
    logic        key_pressed;
    logic        caps_lock_on;
    logic        target_present;
  } item_t;

  typedef struct packed {
    logic ctrl;
    logic shift;
    logic alt;
  } mods_t;

  typedef struct packed {
    kind_t      event_kind;
    logic [3:0] key_code;
    logic [3:0] function_number;
    logic [6:0] character;
    logic       shift_flag;
    logic       ctrl_flag;
    logic       alt_flag;
  } result_t;

  // Punctuation / digit row, usages 0x1e..0x38; 0 means unmapped.
  function automatic logic [6:0] punct_char(input logic [4:0] idx, input logic shifted);
    logic [6:0] p;
    logic [6:0] s;
    begin
      p = 7'd0;
      s = 7'd0;
      case (idx)
        5'd0:  begin p = 7'h31; s = 7'h21; end // 1 !
        5'd1:  begin p = 7'h32; s = 7'h40; end // 2 @
        5'd2:  begin p = 7'h33; s = 7'h23; end // 3 #
        5'd3:  begin p = 7'h34; s = 7'h24; end // 4 $
        5'd4:  begin p = 7'h35; s = 7'h25; end // 5 %
        5'd5:  begin p = 7'h36; s = 7'h5e; end // 6 ^
        5'd6:  begin p = 7'h37; s = 7'h26; end // 7 &
        5'd7:  begin p = 7'h38; s = 7'h2a; end // 8 *
        5'd8:  begin p = 7'h39; s = 7'h28; end // 9 (
        5'd9:  begin p = 7'h30; s = 7'h29; end // 0 )
        5'd14: begin p = 7'h20; s = 7'h20; end // space
        5'd15: begin p = 7'h2d; s = 7'h5f; end // - _
        5'd16: begin p = 7'h3d; s = 7'h2b; end // = +
        5'd17: begin p = 7'h5b; s = 7'h7b; end // [ {
        5'd18: begin p = 7'h5d; s = 7'h7d; end // ] }
        5'd19: begin p = 7'h5c; s = 7'h7c; end // \ |
        5'd21: begin p = 7'h3b; s = 7'h3a; end // ; :
        5'd22: begin p = 7'h27; s = 7'h22; end // ' "
        5'd23: begin p = 7'h60; s = 7'h7e; end // ` ~
        5'd24: begin p = 7'h2c; s = 7'h3c; end // , <
        5'd25: begin p = 7'h2e; s = 7'h3e; end // . >
        5'd26: begin p = 7'h2f; s = 7'h3f; end // / ?
        default: begin p = 7'd0; s = 7'd0; end
      endcase
      punct_char = shifted ? s : p;
    end
  endfunction

endpackage

FILE: src/hktt_decode.sv
// ----------------------------------------------------------------------------
// hktt_decode
// Combinational decode of one key item against the held modifier flags.
// ----------------------------------------------------------------------------
module hktt_decode (
  input  hktt_pkg::item_t   item,
  input  hktt_pkg::mods_t   mods,
  output hktt_pkg::mods_t   mods_nxt,
  output hktt_pkg::result_t res
);
  import hktt_pkg::*;

  logic [15:0] u;
  logic        is_mod;
  logic [6:0]  letter;
  logic [4:0]  pidx;
  logic [6:0]  pch;

  assign u      = item.usage_code;
  assign letter = 7'(7'd93 + u[6:0]);                 // 'a' + (u - 4)
  assign pidx   = 5'(u[7:0] - USAGE_1[7:0]);
  assign pch    = punct_char(pidx, mods.shift);

  always_comb begin
    mods_nxt = mods;
    is_mod   = 1'b0;
    res      = '0;
    if (item.hid_page == PAGE_KEYBOARD) begin
      case (u)
        USAGE_LCTRL,  USAGE_RCTRL:  begin mods_nxt.ctrl  = item.key_pressed; is_mod = 1'b1; end
        USAGE_LSHIFT, USAGE_RSHIFT: begin mods_nxt.shift = item.key_pressed; is_mod = 1'b1; end
        USAGE_LALT,   USAGE_RALT:   begin mods_nxt.alt   = item.key_pressed; is_mod = 1'b1; end
        USAGE_LGUI,   USAGE_RGUI:   is_mod = 1'b1;
        default:                    is_mod = 1'b0;
      endcase

      if (!is_mod && item.key_pressed && item.target_present) begin
        res.shift_flag = mods.shift;
        res.ctrl_flag  = mods.ctrl;
        res.alt_flag   = mods.alt;
        res.event_kind = KIND_NAMED;
        case (u)
          16'h0028: res.key_code = KEY_ENTER;
          16'h0029: res.key_code = KEY_ESCAPE;
          16'h002a: res.key_code = KEY_BKSP;
          16'h002b: res.key_code = KEY_TAB;
          16'h0052: res.key_code = KEY_UP;
          16'h0051: res.key_code = KEY_DOWN;
          16'h0050: res.key_code = KEY_LEFT;
          16'h004f: res.key_code = KEY_RIGHT;
          16'h004a: res.key_code = KEY_HOME;
          16'h004d: res.key_code = KEY_END;
          16'h0049: res.key_code = KEY_INSERT;
          16'h004c: res.key_code = KEY_DELETE;
          16'h004b: res.key_code = KEY_PGUP;
          16'h004e: res.key_code = KEY_PGDN;
          default:  res.event_kind = KIND_NONE;
        endcase

        if ((u == USAGE_INSERT && mods.shift) ||
            (u == USAGE_V && mods.shift && mods.ctrl)) begin
          res = '0;
          res.event_kind = KIND_PASTE;
        end else if (res.event_kind == KIND_NAMED) begin
          // named key already filled in
        end else if (u >= USAGE_F1 && u <= USAGE_F12) begin
          res.event_kind      = KIND_FUNC;
          res.function_number = 4'(u[3:0] - USAGE_F1[3:0] + 4'd1);
        end else begin
          res.shift_flag = 1'b0;
          if (u >= USAGE_A && u <= USAGE_Z) begin
            res.event_kind = KIND_CHAR;
            res.character  = (mods.shift != item.caps_lock_on) ? 7'(letter - 7'd32) : letter;
          end else if (u >= USAGE_1 && u <= USAGE_SLASH && pch != 7'd0) begin
            res.event_kind = KIND_CHAR;
            res.character  = pch;
          end
          if (res.event_kind == KIND_NONE) begin
            res = '0;
          end
        end
      end
    end
  end

endmodule

FILE: src/hid_key_to_terminal_input.sv
// ----------------------------------------------------------------------------
// hid_key_to_terminal_input
// USB HID keyboard events (US layout) to terminal input events.
// ----------------------------------------------------------------------------
// Every accepted item gives exactly one result, which passes through the input
// register and then the result register; one item per cycle is sustained while
// the output side is not stalled. The block has
// two stages: an input register, then a short table decode into the result
// register. The held ctrl/shift/alt flags are updated as an item passes the
// decode stage, so each item sees the modifiers left by all earlier items.
// Left and right modifier keys share one flag. Results of kind none (other
// pages, modifier and GUI keys, releases, no target, unmapped usages) are
// still delivered, with all other fields zero. Stall on the input side rises
// only when both registers are full and the output side stalls.
// ----------------------------------------------------------------------------
module hid_key_to_terminal_input (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_hid_page,
  input  logic [15:0] in_usage_code,
  input  logic        in_key_pressed,
  input  logic        in_caps_lock_on,
  input  logic        in_target_present,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_event_kind,
  output logic [3:0]  out_key_code,
  output logic [3:0]  out_function_number,
  output logic [6:0]  out_character,
  output logic        out_shift_flag,
  output logic        out_ctrl_flag,
  output logic        out_alt_flag
);
  import hktt_pkg::*;

  // stage 1: input register
  logic    in_valid_r;
  item_t   item_r;
  // stage 2: result register
  logic    out_valid_r;
  result_t res_r;
  // held modifiers
  mods_t   mods_r;
  mods_t   mods_nxt;
  result_t res_nxt;

  logic advance;   // item moves from input register into result register
  logic load_in;   // new item taken into input register

  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !advance;
  assign load_in  = in_valid && !in_stall;

  hktt_decode u_decode (
    .item     (item_r),
    .mods     (mods_r),
    .mods_nxt (mods_nxt),
    .res      (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      mods_r      <= '0;
    end else begin
      if (load_in) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        mods_r      <= mods_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (load_in) begin
      item_r.hid_page       <= in_hid_page;
      item_r.usage_code     <= in_usage_code;
      item_r.key_pressed    <= in_key_pressed;
      item_r.caps_lock_on   <= in_caps_lock_on;
      item_r.target_present <= in_target_present;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_event_kind      = res_r.event_kind;
  assign out_key_code        = res_r.key_code;
  assign out_function_number = res_r.function_number;
  assign out_character       = res_r.character;
  assign out_shift_flag      = res_r.shift_flag;
  assign out_ctrl_flag       = res_r.ctrl_flag;
  assign out_alt_flag        = res_r.alt_flag;

`ifndef NO_ASSERTIONS
  // A character only travels with a character event.
  a_char_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.event_kind != KIND_CHAR |-> res_r.character == 7'd0)
    else $error("character set on non-character event");

  // Function key numbers stay in 1..12.
  a_fn_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.event_kind == KIND_FUNC |->
      res_r.function_number >= 4'd1 && res_r.function_number <= 4'd12)
    else $error("function number out of range");

  // A stalled result is held until taken.
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(res_r))
    else $error("stalled result changed");

  // Modifier flags move only when an item passes decode.
  a_mods_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(mods_r))
    else $error("modifier flags changed without an item");
`endif

endmodule
